/* hdl/oi3_pkg.sv */
`default_nettype none
package oi3_pkg;

    // configuration register map
    localparam int CFG_W     = 11;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // frame geometry
    localparam int ROW_W          = 11;
    localparam int MIN_DIM        = 3;
    localparam int MAX_HEIGHT     = 1024;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam int WIN_W = 9;

    typedef struct packed {
        logic       kind;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // per-item control handed from front to back
    typedef struct packed {
        logic occ;
        logic row_ge1;
        logic row_ge2;
        logic col_zero;
        logic emit;
        logic frame_end;
    } cmd_flags_t;

endpackage
`default_nettype wire

/* hdl/oi3_front.sv */
`default_nettype none
module oi3_front
    import oi3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int COL_W     = $clog2(MAX_WIDTH),
    parameter int CMD_W     = COL_W + $bits(cmd_flags_t) + $bits(pixel_t)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_valid,
    input  wire in_item_t             s_data,
    input  wire logic                 room,
    output logic                      s_ready,
    output logic                      restart,
    output logic                      push_valid,
    output logic [CMD_W-1:0]          push_data
);

    localparam int DIM_W = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int CMP_W = DIM_W + 1;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [COL_W-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;

    logic [CMP_W-1:0] w_eff, in_col_ext, out_col_ext;
    logic [ROW_W-1:0] h_eff;
    logic draining, occ, emit, frame_end, drop, accept, last_in_col, last_out_col;
    logic rgb_zero, interior;
    cmd_flags_t flags;
    pixel_t     pix;

    // decode configuration writes
    assign restart = cfg_wr_en &&
                     (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(RESET_WIDTH);
            height_reg <= CFG_W'(RESET_HEIGHT);
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_FRAME_WIDTH)  width_reg  <= cfg_data;
            if (cfg_index == REG_FRAME_HEIGHT) height_reg <= cfg_data;
        end
    end

    // clamp frame geometry
    always_comb begin
        w_eff = CMP_W'(width_reg);
        if (w_eff < CMP_W'(MIN_DIM))   w_eff = CMP_W'(MIN_DIM);
        if (w_eff > CMP_W'(MAX_WIDTH)) w_eff = CMP_W'(MAX_WIDTH);
        h_eff = height_reg;
        if (h_eff < ROW_W'(MIN_DIM))    h_eff = ROW_W'(MIN_DIM);
        if (h_eff > ROW_W'(MAX_HEIGHT)) h_eff = ROW_W'(MAX_HEIGHT);
    end

    // classify the item at the input
    always_comb begin
        in_col_ext   = CMP_W'(in_col_reg);
        out_col_ext  = CMP_W'(out_col_reg);
        draining     = in_row_reg >= h_eff;
        rgb_zero     = s_data.red_in == 8'd0 && s_data.green_in == 8'd0 &&
                       s_data.blue_in == 8'd0;
        interior     = in_row_reg >= ROW_W'(1) && (in_row_reg + ROW_W'(2)) <= h_eff &&
                       in_col_reg != '0 && (in_col_ext + CMP_W'(2)) <= w_eff;
        occ          = !draining && rgb_zero && interior;
        emit         = in_row_reg >= ROW_W'(2) ||
                       (in_row_reg == ROW_W'(1) && in_col_reg != '0);
        last_in_col  = (in_col_ext + CMP_W'(1)) >= w_eff;
        last_out_col = (out_col_ext + CMP_W'(1)) >= w_eff;
        frame_end    = emit && last_out_col && (out_row_reg + ROW_W'(1)) >= h_eff;
        drop         = s_data.kind && !draining;

        pix.red   = draining ? 8'd0 : s_data.red_in;
        pix.green = draining ? 8'd0 : s_data.green_in;
        pix.blue  = draining ? 8'd0 : s_data.blue_in;
        pix.alpha = draining ? 8'd0 : s_data.alpha_in;

        flags.occ       = occ;
        flags.row_ge1   = in_row_reg >= ROW_W'(1);
        flags.row_ge2   = in_row_reg >= ROW_W'(2);
        flags.col_zero  = in_col_reg == '0;
        flags.emit      = emit;
        flags.frame_end = frame_end;
    end

    assign s_ready    = room;
    assign accept     = s_valid && s_ready;
    assign push_valid = accept && !drop;
    assign push_data  = {in_col_reg, flags, pix};

    // advance input and output positions
    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (push_valid) begin
            if (frame_end) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else begin
                if (last_in_col) begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end else begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
                if (emit) begin
                    if (last_out_col) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end else begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/oi3_queue.sv */
`default_nettype none
module oi3_queue
    import oi3_pkg::*;
#(
    parameter int DATA_W = 48
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_data
);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;
    logic push, pop;

    assign in_ready  = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // track fill level
    always_comb begin
        count_next = count_reg;
        if (push && !pop)      count_next = count_reg + (QPTR_W + 1)'(1);
        else if (pop && !push) count_next = count_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    // store entries
    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= in_data;
    end

endmodule
`default_nettype wire

/* hdl/oi3_back.sv */
`default_nettype none
module oi3_back
    import oi3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int COL_W     = $clog2(MAX_WIDTH),
    parameter int CMD_W     = COL_W + $bits(cmd_flags_t) + $bits(pixel_t)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             restart,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire logic [CMD_W-1:0] q_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_item_t             m_data
);

    // line stores: occupancy {row-2, row-1} and the pixel one row back
    logic [1:0] occ_mem [MAX_WIDTH];
    pixel_t     pix_mem [MAX_WIDTH];

    logic [COL_W-1:0] q_col;
    cmd_flags_t       q_flags;
    pixel_t           q_pix;

    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    cmd_flags_t       s1_flags_reg;
    pixel_t           s1_pix_reg;
    logic [1:0]       occ_rd_reg;
    pixel_t           pix_rd_reg;

    logic [WIN_W-1:0] window_reg, window_next, win;
    pixel_t           held_reg, held_next;
    logic [2:0]       triple;
    logic             m_valid_reg, consume, pop;
    out_item_t        out_reg;

    assign {q_col, q_flags, q_pix} = q_data;

    assign consume = s1_valid_reg && (!m_valid_reg || m_ready);
    assign pop     = q_valid && (!s1_valid_reg || consume);
    assign q_ready = pop;

    // launch line reads on pop, write back when the item is carried out
    always_ff @(posedge aclk) begin
        if (pop) begin
            occ_rd_reg   <= occ_mem[q_col];
            pix_rd_reg   <= pix_mem[q_col];
            s1_col_reg   <= q_col;
            s1_flags_reg <= q_flags;
            s1_pix_reg   <= q_pix;
        end
        if (consume) begin
            occ_mem[s1_col_reg] <= {occ_rd_reg[0], s1_flags_reg.occ};
            pix_mem[s1_col_reg] <= s1_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (pop) begin
            s1_valid_reg <= 1'b1;
        end else if (consume) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // build the 3x3 window and pick the delayed pixel
    always_comb begin
        triple = {s1_flags_reg.row_ge2 & occ_rd_reg[1],
                  s1_flags_reg.row_ge1 & occ_rd_reg[0],
                  s1_flags_reg.occ};
        if (s1_flags_reg.col_zero) begin
            win         = {window_reg[WIN_W-4:0], 3'b000};
            window_next = WIN_W'(triple);
        end else begin
            window_next = {window_reg[WIN_W-4:0], triple};
            win         = window_next;
        end
        held_next = pix_rd_reg;
        if (s1_flags_reg.frame_end) begin
            window_next = '0;
            held_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            window_reg <= '0;
            held_reg   <= '0;
        end else if (consume) begin
            window_reg <= window_next;
            held_reg   <= held_next;
        end
    end

    // hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (consume && s1_flags_reg.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && s1_flags_reg.emit) begin
            out_reg.red_out   <= (win != '0) ? 8'd0 : held_reg.red;
            out_reg.green_out <= (win != '0) ? 8'd0 : held_reg.green;
            out_reg.blue_out  <= (win != '0) ? 8'd0 : held_reg.blue;
            out_reg.alpha_out <= held_reg.alpha;
            out_reg.frame_end <= s1_flags_reg.frame_end;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

/* hdl/obstacle_inflation_3x3.sv */
// Streaming 3x3 obstacle inflation of an RGBA image.
// Input channel s_valid/s_ready/s_data carries one item per beat: a pixel
// (kind = 0) in raster order, or a flush tick (kind = 1). A pixel whose red,
// green and blue are all zero and that lies inside the frame border blackens
// its 3x3 neighborhood (alpha kept). Result channel m_valid/m_ready/m_data
// carries the processed pixels; frame_end marks the last pixel of a frame.
// The image comes out frame_width + 1 items behind the input: the first
// frame_width + 1 items of a frame give no beat, each later item gives one.
// After the last pixel of a frame, send frame_width + 1 flush ticks (or any
// items) to drain it; flush ticks sent earlier are dropped.
// Throughput is one item per clock while the command queue has room; the line
// stores have one read and one write port each, used once per item. The
// accepting edge writes the command queue; from there an item passes the line
// store read stage and then the output register, which drives m_valid.
// When m_ready is low, results wait in the output register and the four-entry
// command queue keeps taking items until it is full.
// cfg_wr_en writes frame_width (index 0) or frame_height (index 1) and
// restarts the frame; write only while idle. Reset restores 640 x 480 and
// restarts the frame; the line stores need no clearing.
`default_nettype none
module obstacle_inflation_3x3
    import oi3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMD_W = COL_W + $bits(cmd_flags_t) + $bits(pixel_t);

    logic             restart, push_valid, room, q_valid, q_ready;
    logic [CMD_W-1:0] push_data, q_data;

    // classify incoming beats
    oi3_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .CMD_W     (CMD_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_data     (s_data),
        .room       (room),
        .s_ready    (s_ready),
        .restart    (restart),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    // decouple front from back
    oi3_queue #(
        .DATA_W (CMD_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (room),
        .in_data   (push_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    // line stores, window and output register
    oi3_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .CMD_W     (CMD_W)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (restart),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

/* verif/inflation_monitor.sv */
module inflation_monitor
    import oi3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire in_item_t             s_data,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire out_item_t            m_data,
    output int                        mismatches,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the geometry registers and the streaming state
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             occ_above  [MAX_WIDTH];
    logic             occ_cur    [MAX_WIDTH];
    pixel_t           delay_line [MAX_WIDTH];
    pixel_t           held_pix;
    logic [WIN_W-1:0] window;
    int unsigned      in_col;
    int unsigned      in_row;
    int unsigned      out_col;
    int unsigned      out_row;

    // inflated pixels still owed by the block, oldest first
    out_item_t expected_pixels[$];

    initial begin
        mismatches = 0;
        pending = 0;
    end

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    task automatic restart_frame();
        held_pix = '0;
        window = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endtask

    // Advance the dilation state by one accepted beat and queue the pixel it releases
    task automatic dilate_item(input in_item_t it);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        logic        draining;
        logic        occ;
        logic        emit;
        logic [2:0]  triple;
        logic [WIN_W-1:0] win;
        pixel_t      pix;
        pixel_t      outpix;
        out_item_t   res;

        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        draining = (in_row >= h);
        col = in_col;
        row = in_row;
        pix = '0;
        occ = 1'b0;

        // drop flush ticks while the frame is still coming in
        if (it.kind && !draining) return;

        // pixels during the drain count as flush ticks
        if (!draining) begin
            pix.red   = it.red_in;
            pix.green = it.green_in;
            pix.blue  = it.blue_in;
            pix.alpha = it.alpha_in;
            occ = (it.red_in == 0) && (it.green_in == 0) && (it.blue_in == 0) &&
                  (row >= 1) && (row + 2 <= h) && (col >= 1) && (col + 2 <= w);
        end

        // vertical triple: two rows up, one row up, this row
        triple[0] = occ;
        triple[1] = (row >= 1) ? occ_cur[col] : 1'b0;
        triple[2] = (row >= 2) ? occ_above[col] : 1'b0;
        occ_above[col] = occ_cur[col];
        occ_cur[col] = occ;

        // slide the window; a new row starts with an empty left edge
        if (in_col == 0) begin
            win = {window[5:0], 3'b000};
            window = {6'b0, triple};
        end else begin
            window = {window[5:0], triple};
            win = window;
        end

        outpix = held_pix;
        held_pix = delay_line[col];
        delay_line[col] = pix;

        emit = (row >= 2) || (row == 1 && in_col >= 1);

        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end

        if (!emit) return;

        if (win != 0) begin
            outpix.red   = '0;
            outpix.green = '0;
            outpix.blue  = '0;
        end
        res.red_out   = outpix.red;
        res.green_out = outpix.green;
        res.blue_out  = outpix.blue;
        res.alpha_out = outpix.alpha;
        res.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
        expected_pixels.push_back(res);

        if (res.frame_end) begin
            restart_frame();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg = CFG_W'(RESET_WIDTH);
            height_reg = CFG_W'(RESET_HEIGHT);
            foreach (occ_above[i]) begin
                occ_above[i] = 1'b0;
                occ_cur[i] = 1'b0;
                delay_line[i] = '0;
            end
            restart_frame();
            expected_pixels.delete();
            mismatches = 0;
        end else begin
            // compare the result beat before predicting from this edge's input
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result beat r=%0h g=%0h b=%0h a=%0h end=%0b",
                                 $time, m_data.red_out, m_data.green_out, m_data.blue_out,
                                 m_data.alpha_out, m_data.frame_end);
                    mismatches++;
                end else begin
                    out_item_t want;
                    want = expected_pixels.pop_front();
                    if (m_data.red_out !== want.red_out ||
                        m_data.green_out !== want.green_out ||
                        m_data.blue_out !== want.blue_out ||
                        m_data.alpha_out !== want.alpha_out ||
                        m_data.frame_end !== want.frame_end) begin
                        if (mismatches < 10)
                            $display({"%0t: pixel mismatch: expected r=%0h g=%0h b=%0h a=%0h ",
                                      "end=%0b, got r=%0h g=%0h b=%0h a=%0h end=%0b"},
                                     $time, want.red_out, want.green_out, want.blue_out,
                                     want.alpha_out, want.frame_end, m_data.red_out,
                                     m_data.green_out, m_data.blue_out, m_data.alpha_out,
                                     m_data.frame_end);
                        mismatches++;
                    end
                end
            end

            // geometry writes restart the frame; other indexes are ignored
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FRAME_WIDTH: begin
                        width_reg = cfg_data;
                        restart_frame();
                    end
                    REG_FRAME_HEIGHT: begin
                        height_reg = cfg_data;
                        restart_frame();
                    end
                    default: ;
                endcase
            end

            if (s_valid && s_ready)
                dilate_item(s_data);
        end
        pending = expected_pixels.size();
    end

endmodule

/* verif/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import oi3_pkg::*;

    localparam int LIMIT         = 2_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 620;
    localparam int LONG_HOLD     = 400;
    localparam int TALL_ITEMS    = 30;

    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int holds_asked = 0;
    int holds_done  = 0;
    int counted_items = 0;

    always #10 aclk = ~aclk;

    obstacle_inflation_3x3 #(
        .MAX_WIDTH(1024)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    inflation_monitor #(
        .MAX_WIDTH(1024)
    ) u_monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic in_item_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                            logic [7:0] a);
        in_item_t it;
        it.kind = KIND_PIXEL;
        it.red_in = r;
        it.green_in = g;
        it.blue_in = b;
        it.alpha_in = a;
        return it;
    endfunction

    function automatic in_item_t flush_item();
        in_item_t it;
        it = make_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        it.kind = KIND_FLUSH;
        return it;
    endfunction

    // random pixel, occupied with the given odds, sometimes one channel short of it
    function automatic in_item_t random_pixel(int occ_pct);
        in_item_t it;
        int sel;
        it = make_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        sel = $urandom_range(0, 99);
        if (sel < occ_pct + 10) begin
            it.red_in = '0;
            it.green_in = '0;
            it.blue_in = '0;
        end
        if (sel >= occ_pct && sel < occ_pct + 10) begin
            case ($urandom_range(0, 2))
                0: it.red_in = 8'($urandom_range(1, 255));
                1: it.green_in = 8'($urandom_range(1, 255));
                default: it.blue_in = 8'($urandom_range(1, 255));
            endcase
        end
        return it;
    endfunction

    // offer one beat, holding valid and payload until it is taken
    task automatic send_item(input in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and wait for every owed pixel plus the pipeline tail
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_geometry(input int w_val, input int h_val);
        write_reg(REG_FRAME_WIDTH, CFG_W'(w_val));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(h_val));
    endtask

    // one whole frame with stray flush ticks, then the drain beats
    task automatic run_frame(input int w, input int h, input int occ_pct, input int noise_pct);
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(flush_item());
            send_item(random_pixel(occ_pct));
            counted_items++;
        end
        for (int i = 0; i <= w; i++) begin
            if ($urandom_range(0, 99) < 20)
                send_item(random_pixel(occ_pct));
            else
                send_item(flush_item());
            counted_items++;
        end
    endtask

    // result side: random ready runs, plus a long hold whenever one is asked for
    initial begin
        int run;
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            run = $urandom_range(1, 20);
            repeat (run) @(posedge aclk);
            if (holds_done < holds_asked) begin
                holds_done++;
                gap = LONG_HOLD;
            end else begin
                gap = pick_gap();
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        int  w;
        int  h;
        int  cur_w;
        int  cur_h;
        int  wv;
        int  hv;
        int  occ;
        int  mode;
        int  n;
        bit  restart_needed;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 3x3 with an unoccupied center and some black border pixels: nothing may be inflated
        set_geometry(3, 3);
        send_item(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF));
        send_item(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00));
        send_item(make_pixel(8'h00, 8'h00, 8'h00, 8'h80));
        send_item(flush_item());
        send_item(make_pixel(8'h00, 8'h00, 8'h00, 8'h01));
        send_item(make_pixel(8'h01, 8'h00, 8'h00, 8'hFE));
        send_item(make_pixel(8'h00, 8'h00, 8'h00, 8'h7F));
        send_item(make_pixel(8'h00, 8'h01, 8'h00, 8'h55));
        send_item(make_pixel(8'h00, 8'h00, 8'h80, 8'hAA));
        send_item(make_pixel(8'h00, 8'h00, 8'h00, 8'h00));
        send_item(flush_item());
        send_item(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_item(flush_item());
        send_item(flush_item());

        // occupied center blackens the whole 3x3; unused indexes must not restart it
        send_item(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_pixel(8'hFF, 8'h00, 8'h7F, 8'h00));
        send_item(make_pixel(8'h80, 8'hFF, 8'h01, 8'h3C));
        send_item(make_pixel(8'h00, 8'hFF, 8'hFF, 8'hC3));
        settle();
        write_reg(REG_SPARE_LO, CFG_W'($urandom_range(0, 2047)));
        write_reg(REG_SPARE_HI, CFG_W'($urandom_range(0, 2047)));
        send_item(make_pixel(8'h00, 8'h00, 8'h00, 8'h5A));
        send_item(make_pixel(8'hFF, 8'hFF, 8'h00, 8'hFF));
        send_item(make_pixel(8'h7F, 8'h80, 8'hFE, 8'h01));
        send_item(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h80));
        send_item(make_pixel(8'h01, 8'h02, 8'h04, 8'h08));
        send_item(flush_item());
        send_item(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF));
        send_item(flush_item());
        send_item(flush_item());
        settle();

        // below-minimum values clamp to 3x3
        set_geometry(0, 2);
        run_frame(3, 3, 30, 10);
        settle();

        // random frames, mostly well formed, with a long result hold early on
        holds_asked++;
        counted_items = 0;
        restart_needed = 1'b1;
        cur_w = 3;
        cur_h = 3;
        while (counted_items < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            if (restart_needed || $urandom_range(0, 99) < 60) begin
                settle();
                wv = (w == 3 && $urandom_range(0, 1)) ? $urandom_range(0, 2) : w;
                hv = (h == 3 && $urandom_range(0, 1)) ? $urandom_range(0, 2) : h;
                set_geometry(wv, hv);
                cur_w = w;
                cur_h = h;
                restart_needed = 1'b0;
            end
            occ = $urandom_range(0, 40);
            mode = $urandom_range(0, 99);
            if (mode < 75) begin
                run_frame(cur_w, cur_h, occ, 5);
            end else if (mode < 90) begin
                // cut the frame off somewhere, drain included
                n = $urandom_range(1, cur_w * cur_h + cur_w);
                repeat (n) begin
                    if ($urandom_range(0, 99) < 20)
                        send_item(flush_item());
                    else
                        send_item(random_pixel(occ));
                    counted_items++;
                end
                restart_needed = 1'b1;
            end else begin
                // noise: pixels and flush ticks in any order
                n = $urandom_range(5, 30);
                repeat (n) begin
                    if ($urandom_range(0, 1)) begin
                        send_item(flush_item());
                    end else begin
                        send_item(random_pixel(occ));
                        counted_items++;
                    end
                end
                restart_needed = 1'b1;
            end
        end
        settle();

        // above-maximum height clamps; run the first rows of a tall frame
        set_geometry(3, 2047);
        repeat (TALL_ITEMS) send_item(random_pixel(30));
        settle();

        if (mismatches == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
